// ===== rtl/mcu16_pkg.sv =====
// package: function codes, flag positions and queue entry type
`default_nettype none
package mcu16_pkg;

  localparam int REG_COUNT_DEF = 16;
  localparam int MEM_WORD_ADDR_BITS_DEF = 15;

  typedef enum logic [4:0] {
    FN_RRC = 5'd0, FN_RRA = 5'd1, FN_SWPB = 5'd2, FN_SXT = 5'd3,
    FN_PUSH = 5'd4, FN_POP = 5'd5, FN_CALL = 5'd6, FN_RET = 5'd7,
    FN_RETI = 5'd8, FN_BR = 5'd9, FN_JMP = 5'd10, FN_JNE = 5'd11,
    FN_JEQ = 5'd12, FN_JNC = 5'd13, FN_JC = 5'd14, FN_JN = 5'd15,
    FN_JGE = 5'd16, FN_JL = 5'd17
  } func_t;

  localparam int FLAG_C_BIT = 0;
  localparam int FLAG_Z_BIT = 1;
  localparam int FLAG_N_BIT = 2;
  localparam int FLAG_V_BIT = 8;

  localparam logic [3:0] PC_REG = 4'd0;
  localparam logic [3:0] SP_REG = 4'd1;
  localparam logic [3:0] SR_REG = 4'd2;

  typedef struct packed {
    logic [4:0]  func;
    logic        valid_func;
    logic        byte_mode;
    logic        in_mem;
    logic [3:0]  reg_index;
    logic [15:0] mem_address;
    logic [15:0] target;
    logic [15:0] return_address;
  } instr_t;

endpackage
`default_nettype wire

// ===== rtl/mcu16_front.sv =====
// front end: takes items, classifies the function code, feeds a two-entry queue
`default_nettype none
module mcu16_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire [47:0]           in_tdata,
  input  wire [11:0]           in_tuser,
  output logic                 q_valid,
  output mcu16_pkg::instr_t    q_item,
  input  wire                  q_pop
);
  import mcu16_pkg::*;

  instr_t     entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  instr_t     cls;
  logic       push;

  always_comb begin
    cls.func           = in_tuser[4:0];
    cls.byte_mode      = in_tuser[5];
    cls.in_mem         = in_tuser[6];
    cls.reg_index      = in_tuser[10:7];
    cls.mem_address    = in_tdata[15:0];
    cls.target         = in_tdata[31:16];
    cls.return_address = in_tdata[47:32];
    cls.valid_func     = (in_tuser[4:0] <= FN_JL);
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != 2'd0) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("bad queue count");
endmodule
`default_nettype wire

// ===== rtl/mcu16_back.sv =====
// back end: two-phase execute with register file, data memory and output register
`default_nettype none
module mcu16_back #(
  parameter int REG_COUNT          = mcu16_pkg::REG_COUNT_DEF,
  parameter int MEM_WORD_ADDR_BITS = mcu16_pkg::MEM_WORD_ADDR_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  input  mcu16_pkg::instr_t    q_item,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [63:0]          out_tdata,
  output logic                 out_tuser
);
  import mcu16_pkg::*;

  localparam int RI_BITS = $clog2(REG_COUNT);
  localparam int MEM_WORDS = 1 << MEM_WORD_ADDR_BITS;

  logic [15:0] rf_r [REG_COUNT];
  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rd_data_r;

  // phase 0: memory read issued; phase 1: execute and write back
  logic        phase_r;
  logic        first_r;   // reti first pop done, second pending
  logic [15:0] saved_r;   // status word popped by reti
  logic [15:0] res_r, sr_o_r, npc_r, sp_o_r;
  logic        tak_r;

  instr_t      it;
  logic [15:0] sr, sp, reg_val, src, res, new_sr, npc, new_sp, wr_data;
  logic [15:0] msb, top, rd_addr;
  logic [MEM_WORD_ADDR_BITS-1:0] rd_idx, wr_idx;
  logic        bsel, taken, rf_we, mem_we, done, cond, need_rd, again;
  logic [RI_BITS-1:0] rf_wi;
  logic [15:0] rf_wd;
  logic        sr_set;

  assign it      = q_item;
  assign sr      = rf_r[SR_REG[RI_BITS-1:0]];
  assign sp      = rf_r[SP_REG[RI_BITS-1:0]];
  assign reg_val = rf_r[it.reg_index[RI_BITS-1:0]];
  assign bsel    = it.byte_mode && (it.func == FN_RRC || it.func == FN_RRA);

  // address needed in phase 0
  always_comb begin
    rd_addr = it.mem_address;
    if (it.func == FN_POP || it.func == FN_RET || it.func == FN_RETI)
      rd_addr = sp;
    rd_idx = rd_addr[MEM_WORD_ADDR_BITS:1];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx] <= wr_data;
    rd_data_r <= mem[rd_idx];
  end

  always_comb begin
    res = 16'd0; new_sr = sr; npc = 16'd0; taken = 1'b0; new_sp = sp;
    rf_we = 1'b0; rf_wi = it.reg_index[RI_BITS-1:0]; rf_wd = 16'd0;
    mem_we = 1'b0; wr_idx = it.mem_address[MEM_WORD_ADDR_BITS:1];
    wr_data = 16'd0; again = 1'b0; sr_set = 1'b0; cond = 1'b0;
    msb = bsel ? 16'h0080 : 16'h8000;
    if (it.in_mem)
      src = bsel ? (it.mem_address[0] ? {8'd0, rd_data_r[15:8]}
                                      : {8'd0, rd_data_r[7:0]}) : rd_data_r;
    else
      src = bsel ? {8'd0, reg_val[7:0]} : reg_val;
    top = 16'd0;
    unique case (it.func)
      FN_RRC, FN_RRA: begin
        top = (it.func == FN_RRC) ? (sr[FLAG_C_BIT] ? msb : 16'd0) : (src & msb);
        res = (src >> 1) | top;
        new_sr[FLAG_C_BIT] = src[0];
        new_sr[FLAG_Z_BIT] = (res == 16'd0);
        new_sr[FLAG_N_BIT] = |(res & msb);
        new_sr[FLAG_V_BIT] = 1'b0;
      end
      FN_SWPB: res = {src[7:0], src[15:8]};
      FN_SXT: begin
        res = {{8{src[7]}}, src[7:0]};
        new_sr[FLAG_C_BIT] = (res != 16'd0);
        new_sr[FLAG_Z_BIT] = (res == 16'd0);
        new_sr[FLAG_N_BIT] = res[15];
        new_sr[FLAG_V_BIT] = 1'b0;
      end
      default: ;
    endcase
    if (it.valid_func && it.func <= FN_SXT) begin
      if (it.in_mem) begin
        mem_we = 1'b1;
        if (bsel)
          wr_data = it.mem_address[0] ? {res[7:0], rd_data_r[7:0]}
                                      : {rd_data_r[15:8], res[7:0]};
        else
          wr_data = res;
      end else begin
        rf_we = 1'b1; rf_wd = res;
        if (it.reg_index == SR_REG) sr_set = 1'b1;
      end
    end
    unique case (it.func)
      FN_PUSH: begin
        res = it.in_mem ? (it.byte_mode ? src : rd_data_r)
                        : (it.byte_mode ? {8'd0, reg_val[7:0]} : reg_val);
        if (it.in_mem && it.byte_mode)
          res = it.mem_address[0] ? {8'd0, rd_data_r[15:8]} : {8'd0, rd_data_r[7:0]};
        new_sp = sp - 16'd2; mem_we = 1'b1;
        wr_idx = new_sp[MEM_WORD_ADDR_BITS:1]; wr_data = res;
      end
      FN_POP: begin
        res = it.byte_mode ? {8'd0, rd_data_r[7:0]} : rd_data_r;
        new_sp = sp + 16'd2;
        rf_we = 1'b1; rf_wd = res;
        if (it.reg_index == SP_REG) new_sp = res;
        if (it.reg_index == SR_REG) sr_set = 1'b1;
      end
      FN_CALL, FN_BR: begin
        npc = it.in_mem ? rd_data_r : (it.byte_mode ? it.target : reg_val);
        taken = 1'b1;
        if (it.func == FN_CALL) begin
          new_sp = sp - 16'd2; mem_we = 1'b1;
          wr_idx = new_sp[MEM_WORD_ADDR_BITS:1]; wr_data = it.return_address;
          res = it.return_address;
        end
      end
      FN_RET: begin npc = rd_data_r; taken = 1'b1; new_sp = sp + 16'd2; end
      FN_RETI: begin
        new_sp = sp + 16'd2;
        if (!first_r) again = 1'b1;
        else begin npc = rd_data_r; taken = 1'b1; new_sr = saved_r; end
      end
      FN_JMP, FN_JNE, FN_JEQ, FN_JNC, FN_JC, FN_JN, FN_JGE, FN_JL: begin
        case (it.func)
          FN_JMP: cond = 1'b1;
          FN_JNE: cond = !sr[FLAG_Z_BIT];
          FN_JEQ: cond = sr[FLAG_Z_BIT];
          FN_JNC: cond = !sr[FLAG_C_BIT];
          FN_JC:  cond = sr[FLAG_C_BIT];
          FN_JN:  cond = sr[FLAG_N_BIT];
          FN_JGE: cond = (sr[FLAG_N_BIT] == sr[FLAG_V_BIT]);
          default: cond = (sr[FLAG_N_BIT] != sr[FLAG_V_BIT]);
        endcase
        if (cond) begin npc = it.target; taken = 1'b1; end
      end
      default: ;
    endcase
    if (!it.valid_func) begin
      res = 16'd0; rf_we = 1'b0; mem_we = 1'b0; taken = 1'b0; npc = 16'd0;
      new_sr = sr; new_sp = sp;
    end
    if (sr_set) new_sr = res;
    // a register result aimed at the stack pointer replaces the stack update
    if (rf_we && it.reg_index == SP_REG) new_sp = rf_wd;
    // gate everything to the execute phase with a free output register
    done = q_valid && phase_r && (!out_tvalid || out_tready);
    if (!done) begin rf_we = 1'b0; mem_we = 1'b0; end
    if (again) begin rf_we = 1'b0; mem_we = 1'b0; end
  end

  assign need_rd = 1'b1;
  assign q_pop = done && !again;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) rf_r[i] <= 16'd0;
      phase_r <= 1'b0; first_r <= 1'b0; out_tvalid <= 1'b0;
    end else begin
      if (out_tready && !q_pop) out_tvalid <= 1'b0;
      if (q_valid && !phase_r && need_rd) phase_r <= 1'b1;
      if (done) begin
        phase_r <= 1'b0;
        if (again) begin
          first_r <= 1'b1;
          rf_r[SP_REG[RI_BITS-1:0]] <= new_sp;
        end else begin
          first_r <= 1'b0;
          out_tvalid <= 1'b1;
          // status and stack pointer go through their own update
          if (rf_we && rf_wi != SR_REG[RI_BITS-1:0] && rf_wi != SP_REG[RI_BITS-1:0])
            rf_r[rf_wi] <= rf_wd;
          rf_r[SR_REG[RI_BITS-1:0]] <= new_sr;
          rf_r[SP_REG[RI_BITS-1:0]] <= new_sp;
          if (taken) rf_r[PC_REG[RI_BITS-1:0]] <= npc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done && again) saved_r <= rd_data_r;
    if (done && !again) begin
      res_r  <= res;
      sr_o_r <= new_sr;
      npc_r  <= taken ? npc : 16'd0;
      tak_r  <= taken;
      sp_o_r <= new_sp;
    end
  end

  assign out_tdata = {sp_o_r, npc_r, sr_o_r, res_r};
  assign out_tuser = tak_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_pop_phase: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> phase_r) else $error("pop outside execute phase");
  a_reti_two: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> q_valid) else $error("reti lost its item");
endmodule
`default_nettype wire

// ===== rtl/mcu16_single_operand_execute_core.sv =====
// top level: single-operand, stack and jump execute core
// input channel in_*: one instruction item per handshake, fields in tdata and tuser
// output channel out_*: one result item per instruction, in order
// the front end queues up to two items so input is taken while a result waits
// the back end takes each item through a memory read phase, then an execute and write phase;
// reti repeats them for its second word, as it pops two words through the single memory read port
// an accepted item passes the queue, the read phase and the execute phase before the result is valid
// a stalled receiver holds the result register; the queue then fills and
// in_tready drops
// synchronous active-low reset clears register file, queue and valids;
// data memory is not cleared and holds garbage until written
`default_nettype none
module mcu16_single_operand_execute_core #(
  parameter int REG_COUNT          = mcu16_pkg::REG_COUNT_DEF,
  parameter int MEM_WORD_ADDR_BITS = mcu16_pkg::MEM_WORD_ADDR_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // mem_address, target, return_address
  input  wire  [11:0] in_tuser,   // func, byte_mode, operand_in_memory, reg_index
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // result, status, next_pc, stack_pointer
  output logic        out_tuser   // branch_taken
);
  import mcu16_pkg::*;

  logic   q_valid, q_pop;
  instr_t q_item;

  mcu16_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_valid, .q_item, .q_pop
  );

  mcu16_back #(.REG_COUNT(REG_COUNT), .MEM_WORD_ADDR_BITS(MEM_WORD_ADDR_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );
endmodule
`default_nettype wire

// ===== bench/mcu16_single_operand_execute_core_tb.sv =====
// testbench for the single-operand, stack and jump execute core
`default_nettype none
module mcu16_single_operand_execute_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mcu16_pkg::*;

  typedef struct {
    logic [4:0]  func;
    logic        byte_mode;
    logic        in_mem;
    logic [3:0]  reg_index;
    logic [15:0] mem_address;
    logic [15:0] target;
    logic [15:0] return_address;
  } instr_item_t;

  typedef struct {
    logic [15:0] result;
    logic [15:0] status;
    logic [15:0] next_pc;
    logic        taken;
    logic [15:0] sp;
  } exec_result_t;

  localparam logic [15:0] C_MASK = 16'h0001 << FLAG_C_BIT;
  localparam logic [15:0] Z_MASK = 16'h0001 << FLAG_Z_BIT;
  localparam logic [15:0] N_MASK = 16'h0001 << FLAG_N_BIT;
  localparam logic [15:0] V_MASK = 16'h0001 << FLAG_V_BIT;
  localparam int          N_ITEMS = 1600;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [11:0] in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;

  int mismatches = 0;
  int phase = 0;
  bit hold_off = 1'b0;

  always #2 clk = ~clk;

  mcu16_single_operand_execute_core i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  class exec_scoreboard;
    logic [15:0] regs [16];
    logic [15:0] mem [int];
    int          written [$];
    exec_result_t pending [$];

    function new();
      foreach (regs[i]) regs[i] = '0;
    endfunction

    function int widx(logic [15:0] a);
      return int'(a[15:1]);
    endfunction

    function bit has(logic [15:0] a);
      return mem.exists(widx(a));
    endfunction

    // true when the item reads no memory word that was never written
    function bit legal(instr_item_t it);
      logic [15:0] sp;
      sp = regs[SP_REG];
      case (it.func)
        FN_RRC, FN_RRA, FN_SWPB, FN_SXT, FN_PUSH, FN_CALL, FN_BR:
          return !it.in_mem || has(it.mem_address);
        FN_POP, FN_RET: return has(sp);
        FN_RETI: return has(sp) && has(sp + 16'd2);
        default: return 1'b1;
      endcase
    endfunction

    function void wr(logic [15:0] a, bit b, logic [15:0] v);
      int i;
      i = widx(a);
      if (!mem.exists(i)) begin
        mem[i] = '0;
        written.push_back(i);
      end
      if (!b) mem[i] = v;
      else if (a[0]) mem[i][15:8] = v[7:0];
      else mem[i][7:0] = v[7:0];
    endfunction

    function logic [15:0] rd(logic [15:0] a, bit b);
      logic [15:0] w;
      w = mem[widx(a)];
      if (!b) return w;
      return a[0] ? {8'h00, w[15:8]} : {8'h00, w[7:0]};
    endfunction

    function void set_flags(bit c, bit z, bit n);
      logic [15:0] s;
      s = regs[SR_REG] & ~(C_MASK | Z_MASK | N_MASK | V_MASK);
      if (c) s |= C_MASK;
      if (z) s |= Z_MASK;
      if (n) s |= N_MASK;
      regs[SR_REG] = s;
    endfunction

    function logic [15:0] pop_word();
      logic [15:0] v;
      v = rd(regs[SP_REG], 1'b0);
      regs[SP_REG] = regs[SP_REG] + 16'd2;
      return v;
    endfunction

    function void push_word(logic [15:0] v);
      regs[SP_REG] = regs[SP_REG] - 16'd2;
      wr(regs[SP_REG], 1'b0, v);
    endfunction

    function void note(instr_item_t it);
      exec_result_t e;
      logic [15:0] sr, src, msb, top, s;
      bit b, c, z, n, v, cond;
      e = '{default: '0};
      sr = regs[SR_REG];
      case (it.func)
        FN_RRC, FN_RRA, FN_SWPB, FN_SXT: begin
          b = it.byte_mode && (it.func == FN_RRC || it.func == FN_RRA);
          msb = b ? 16'h0080 : 16'h8000;
          if (it.in_mem) src = rd(it.mem_address, b);
          else src = b ? {8'h00, regs[it.reg_index][7:0]} : regs[it.reg_index];
          if (it.func == FN_RRC || it.func == FN_RRA) begin
            if (it.func == FN_RRC) top = (sr & C_MASK) != 0 ? msb : 16'h0;
            else top = src & msb;
            e.result = (src >> 1) | top;
            set_flags(src[0], e.result == 0, (e.result & msb) != 0);
          end else if (it.func == FN_SWPB) begin
            e.result = {src[7:0], src[15:8]};
          end else begin
            e.result = {{8{src[7]}}, src[7:0]};
            set_flags(e.result != 0, e.result == 0, e.result[15]);
          end
          if (it.in_mem) wr(it.mem_address, b, e.result);
          else regs[it.reg_index] = e.result;
        end
        FN_PUSH: begin
          if (it.in_mem) e.result = rd(it.mem_address, it.byte_mode);
          else e.result = it.byte_mode ? {8'h00, regs[it.reg_index][7:0]}
                                       : regs[it.reg_index];
          push_word(e.result);
        end
        FN_POP: begin
          s = pop_word();
          e.result = it.byte_mode ? {8'h00, s[7:0]} : s;
          regs[it.reg_index] = e.result;
        end
        FN_CALL, FN_BR: begin
          if (it.in_mem) e.next_pc = rd(it.mem_address, 1'b0);
          else e.next_pc = it.byte_mode ? it.target : regs[it.reg_index];
          if (it.func == FN_CALL) begin
            push_word(it.return_address);
            e.result = it.return_address;
          end
          e.taken = 1'b1;
        end
        FN_RET: begin
          e.next_pc = pop_word();
          e.taken = 1'b1;
        end
        FN_RETI: begin
          s = pop_word();
          e.next_pc = pop_word();
          regs[SR_REG] = s;
          e.taken = 1'b1;
        end
        FN_JMP, FN_JNE, FN_JEQ, FN_JNC, FN_JC, FN_JN, FN_JGE, FN_JL: begin
          c = (sr & C_MASK) != 0; z = (sr & Z_MASK) != 0;
          n = (sr & N_MASK) != 0; v = (sr & V_MASK) != 0;
          case (it.func)
            FN_JMP: cond = 1'b1;
            FN_JNE: cond = !z;
            FN_JEQ: cond = z;
            FN_JNC: cond = !c;
            FN_JC:  cond = c;
            FN_JN:  cond = n;
            FN_JGE: cond = (n == v);
            default: cond = (n != v);
          endcase
          if (cond) begin
            e.next_pc = it.target;
            e.taken = 1'b1;
          end
        end
        default: ;
      endcase
      if (e.taken) regs[PC_REG] = e.next_pc;
      else e.next_pc = '0;
      e.status = regs[SR_REG];
      e.sp = regs[SP_REG];
      pending.push_back(e);
    endfunction

    task check(logic [63:0] d, logic taken);
      exec_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", d[15:0], 16'h0);
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.result) report_mismatch("result", d[15:0], e.result);
      if (d[31:16] !== e.status) report_mismatch("status", d[31:16], e.status);
      if (d[47:32] !== e.next_pc) report_mismatch("next_pc", d[47:32], e.next_pc);
      if (d[63:48] !== e.sp) report_mismatch("stack_pointer", d[63:48], e.sp);
      if (taken !== e.taken) report_mismatch("branch_taken", 16'(taken), 16'(e.taken));
    endtask
  endclass

  exec_scoreboard sb = new();

  // random item; memory operands come from words already written
  function automatic instr_item_t random_item();
    instr_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) it.func = 5'($urandom_range(FN_RRC, FN_SXT));
    else if (r < 48) it.func = FN_PUSH;
    else if (r < 56) it.func = FN_CALL;
    else if (r < 64) it.func = FN_POP;
    else if (r < 72) it.func = 5'($urandom_range(FN_RET, FN_RETI));
    else if (r < 77) it.func = FN_BR;
    else if (r < 96) it.func = 5'($urandom_range(FN_JMP, FN_JL));
    else it.func = 5'($urandom_range(18, 31));
    it.byte_mode = 1'($urandom);
    it.reg_index = 4'($urandom);
    it.target = 16'($urandom);
    it.return_address = 16'($urandom);
    it.in_mem = sb.written.size() != 0 && $urandom_range(0, 1);
    if (it.in_mem)
      it.mem_address = {15'(sb.written[$urandom_range(0, sb.written.size() - 1)]),
                        1'($urandom)};
    else it.mem_address = 16'($urandom);
    return it;
  endfunction

  function automatic instr_item_t mk(logic [4:0] f, bit b, bit m, logic [3:0] ri,
                                     logic [15:0] a, logic [15:0] t, logic [15:0] ra);
    instr_item_t it;
    it = '{f, b, m, ri, a, t, ra};
    return it;
  endfunction

  task automatic send(instr_item_t it);
    int gap;
    gap = 0;
    if (phase == 0 && $urandom_range(0, 99) < 11) gap = $urandom_range(1, 4);
    if (phase == 1 && $urandom_range(0, 99) < 61) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {1'b0, it.reg_index, it.in_mem, it.byte_mode, it.func};
    in_tdata <= {it.return_address, it.target, it.mem_address};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note(it);
    @(negedge clk);
  endtask

  // receiver ready, with one long hold-off when the last phase starts
  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (phase == 0) out_tready <= $urandom_range(0, 99) >= 61;
    else if (phase == 1) out_tready <= $urandom_range(0, 99) >= 11;
    else out_tready <= 1'b1;
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tuser);

  initial begin
    #1_500_000;
    $display("mcu16_single_operand_execute_core_tb: FAIL");
    $finish;
  end

  initial begin
    instr_item_t it;
    instr_item_t directed [$];
    int tries;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // build a stack, load registers, flags from reti, then every operation
    directed = '{
      mk(FN_CALL, 1'b1, 1'b0, 4'd0, 16'h0000, 16'hFFFF, 16'hFFFF),
      mk(FN_CALL, 1'b1, 1'b0, 4'd0, 16'hFFFF, 16'h0000, 16'h8001),
      mk(FN_POP, 1'b0, 1'b0, 4'd3, 16'h0, 16'h0, 16'h0),
      mk(FN_POP, 1'b1, 1'b0, 4'd15, 16'h0, 16'h0, 16'h0),
      mk(FN_RRC, 1'b0, 1'b0, 4'd3, 16'h0, 16'h0, 16'h0),
      mk(FN_RRA, 1'b0, 1'b0, 4'd15, 16'h0, 16'h0, 16'h0),
      mk(FN_RRC, 1'b1, 1'b0, 4'd15, 16'h0, 16'h0, 16'h0),
      mk(FN_RRA, 1'b1, 1'b1, 4'd0, 16'hFFFF, 16'h0, 16'h0),
      mk(FN_SWPB, 1'b0, 1'b1, 4'd0, 16'hFFFE, 16'h0, 16'h0),
      mk(FN_SXT, 1'b0, 1'b0, 4'd3, 16'h0, 16'h0, 16'h0),
      mk(FN_SXT, 1'b0, 1'b0, 4'd4, 16'h0, 16'h0, 16'h0),
      mk(FN_PUSH, 1'b0, 1'b0, SP_REG, 16'h0, 16'h0, 16'h0),
      mk(FN_PUSH, 1'b1, 1'b1, 4'd0, 16'hFFFF, 16'h0, 16'h0),
      mk(FN_RRC, 1'b0, 1'b0, SR_REG, 16'h0, 16'h0, 16'h0),
      mk(FN_CALL, 1'b0, 1'b0, 4'd3, 16'h0, 16'h0, 16'h1234),
      mk(FN_BR, 1'b0, 1'b1, 4'd0, 16'hFFFC, 16'h0, 16'h0),
      mk(FN_RET, 1'b0, 1'b0, 4'd0, 16'h0, 16'h0, 16'h0),
      mk(FN_RETI, 1'b0, 1'b0, 4'd0, 16'h0, 16'h0, 16'h0),
      mk(FN_JMP, 1'b0, 1'b0, 4'd0, 16'h0, 16'hAAAA, 16'h0),
      mk(FN_JNE, 1'b0, 1'b0, 4'd0, 16'h0, 16'h5555, 16'h0),
      mk(FN_JEQ, 1'b0, 1'b0, 4'd0, 16'h0, 16'h1111, 16'h0),
      mk(FN_JNC, 1'b0, 1'b0, 4'd0, 16'h0, 16'h2222, 16'h0),
      mk(FN_JC, 1'b0, 1'b0, 4'd0, 16'h0, 16'h3333, 16'h0),
      mk(FN_JN, 1'b0, 1'b0, 4'd0, 16'h0, 16'h4444, 16'h0),
      mk(FN_JGE, 1'b0, 1'b0, 4'd0, 16'h0, 16'h6666, 16'h0),
      mk(FN_JL, 1'b0, 1'b0, 4'd0, 16'h0, 16'h7777, 16'h0),
      mk(5'd31, 1'b1, 1'b1, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF),
      mk(FN_POP, 1'b0, 1'b0, SP_REG, 16'h0, 16'h0, 16'h0)
    };
    foreach (directed[i])
      if (sb.legal(directed[i])) send(directed[i]);
    for (int k = 0; k < N_ITEMS; k++) begin
      if (k == N_ITEMS / 3) phase = 1;
      if (k == 2 * N_ITEMS / 3) begin
        phase = 2;
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      tries = 0;
      do begin
        it = random_item();
        tries++;
      end while (!sb.legal(it) && tries < 50);
      if (!sb.legal(it)) it = mk(FN_CALL, 1'b1, 1'b0, 4'd0, 16'($urandom), 16'($urandom),
                                 16'($urandom));
      send(it);
    end
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("mcu16_single_operand_execute_core_tb: PASS");
    else $display("mcu16_single_operand_execute_core_tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
